// ===== hdl/afd_pkg.sv =====
// Shared types, constants and the CRC byte function of the AF packet deframer.
package afd_pkg;

  localparam int HEADER_BYTES = 10;

  // Header byte positions, counted from the first sync byte.
  localparam logic [15:0] POS_LEN_HI_END = 16'd4;
  localparam logic [15:0] POS_LEN_END    = 16'd6;
  localparam logic [15:0] POS_SEQ_END    = 16'd8;
  localparam logic [15:0] POS_FLAGS      = 16'd8;
  localparam logic [15:0] POS_SYNC_DONE  = 16'd2;
  localparam logic [15:0] POS_HDR_LAST   = 16'(HEADER_BYTES - 1);

  localparam logic [7:0]  CHAR_A       = 8'h41;
  localparam logic [7:0]  CHAR_F       = 8'h46;
  localparam logic [7:0]  CHAR_T       = 8'h54;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] POLY_RESET   = 16'h1021;
  localparam logic [15:0] MAX_LEN_RST  = 16'd8192;
  localparam logic [6:0]  REV_EXPECTED = 7'h10;

  localparam int CFG_INDEX_W = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CRC_POLY = 4'd0,
    CFG_MAX_LEN  = 4'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CRC_HI  = 3'd3,
    PH_CRC_LO  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_CRC     = 3'd1,
    ST_WRONG_TYPE = 3'd2,
    ST_CRC_BAD    = 3'd3,
    ST_TOO_LONG   = 3'd4
  } end_status_t;

  // One byte through an MSB-first CRC-16, eight bit steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/afd_if.sv =====
// Channel interfaces of the AF packet deframer: byte input, result output and register writes.
interface afd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       flush;
  modport source (output valid, output data_byte, output flush, input ready);
  modport sink (input valid, input data_byte, input flush, output ready);
endinterface

interface afd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        byte_valid;
  logic        packet_end;
  logic [2:0]  end_status;
  logic [15:0] sequence_number;
  logic        sequence_gap;
  logic        revision_mismatch;
  modport source (output valid, output payload_byte, output byte_valid, output packet_end,
                  output end_status, output sequence_number, output sequence_gap,
                  output revision_mismatch, input ready);
  modport sink (input valid, input payload_byte, input byte_valid, input packet_end,
                input end_status, input sequence_number, input sequence_gap,
                input revision_mismatch, output ready);
endinterface

interface afd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [afd_pkg::CFG_INDEX_W-1:0] reg_index;
  logic [15:0]                     write_data;
  modport source (output valid, output reg_index, output write_data, input ready);
  modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

// ===== hdl/af_packet_deframer_unit.sv =====
// AF packet deframer: sync hunt, header parse, payload pass-through and CRC check.
// A byte is held in the input register; any result it gives is held in the output register.
// One byte per cycle unless the output stalls; a byte's CRC is eight combinational bit steps.
// The input register lets a new byte enter while a result waits to be taken.
// rst_n is synchronous, active low: hunting, sequence history cleared, registers to defaults.
module af_packet_deframer_unit (
  input  logic       clk,
  input  logic       rst_n,
  afd_in_if.sink     in_if,
  afd_out_if.source  out_if,
  afd_cfg_if.sink    cfg_if
);

  // Configuration
  logic [15:0] poly_r, max_len_r, a_crc_r;

  // Input register
  logic       in_full_r;
  logic [7:0] in_byte_r;
  logic       in_flush_r;
  logic       advance;

  // Deframer state
  afd_pkg::phase_t phase_r, phase_nxt;
  logic        prev_a_r, prev_a_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] len_r, len_nxt;
  logic        len_hi_r, len_hi_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  rx_hi_r, rx_hi_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic        type_ok_r, type_ok_nxt;
  logic [15:0] last_seq_r, last_seq_nxt;
  logic        seq_known_r, seq_known_nxt;
  logic [15:0] cur_seq_r, cur_seq_nxt;

  // Result register
  logic        out_valid_r;
  logic [7:0]  o_byte_r, o_byte_nxt;
  logic        o_bv_r, o_bv_nxt;
  logic        o_end_r, o_end_nxt;
  afd_pkg::end_status_t o_status_r, o_status_nxt;
  logic [15:0] o_seq_r, o_seq_nxt;
  logic        o_gap_r, o_gap_nxt;
  logic        o_rev_r, o_rev_nxt;
  logic        emit;
  logic        finish;
  afd_pkg::end_status_t fin_status;
  logic [16:0] pay_count;

  assign advance     = in_full_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_full_r || advance;
  assign cfg_if.ready = 1'b1;
  assign pay_count   = {1'b0, cnt_r} + 17'd1;

  // Configuration registers; the CRC of the first sync byte follows the polynomial.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r    <= afd_pkg::POLY_RESET;
      max_len_r <= afd_pkg::MAX_LEN_RST;
      a_crc_r   <= afd_pkg::crc_byte(afd_pkg::CRC_INIT, afd_pkg::CHAR_A, afd_pkg::POLY_RESET);
    end else if (cfg_if.valid) begin
      unique case (cfg_if.reg_index)
        afd_pkg::CFG_CRC_POLY: begin
          poly_r  <= cfg_if.write_data;
          a_crc_r <= afd_pkg::crc_byte(afd_pkg::CRC_INIT, afd_pkg::CHAR_A, cfg_if.write_data);
        end
        afd_pkg::CFG_MAX_LEN: max_len_r <= cfg_if.write_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      in_full_r <= 1'b1;
    end else if (advance) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_byte_r  <= in_if.data_byte;
      in_flush_r <= in_if.flush;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    prev_a_nxt    = prev_a_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    len_hi_nxt    = len_hi_r;
    crc_nxt       = crc_r;
    rx_hi_nxt     = rx_hi_r;
    flags_nxt     = flags_r;
    type_ok_nxt   = type_ok_r;
    last_seq_nxt  = last_seq_r;
    seq_known_nxt = seq_known_r;
    cur_seq_nxt   = cur_seq_r;
    emit          = 1'b0;
    finish        = 1'b0;
    fin_status    = afd_pkg::ST_OK;
    o_byte_nxt    = 8'h00;
    o_bv_nxt      = 1'b0;
    o_end_nxt     = 1'b0;
    o_status_nxt  = afd_pkg::ST_OK;
    o_seq_nxt     = 16'h0000;
    o_gap_nxt     = 1'b0;
    o_rev_nxt     = 1'b0;

    if (advance) begin
      if (in_flush_r) begin
        phase_nxt     = afd_pkg::PH_HUNT;
        prev_a_nxt    = 1'b0;
        seq_known_nxt = 1'b0;
      end else begin
        unique case (phase_r)
          afd_pkg::PH_HUNT: begin
            if (prev_a_r && in_byte_r == afd_pkg::CHAR_F) begin
              phase_nxt  = afd_pkg::PH_HEADER;
              prev_a_nxt = 1'b0;
              cnt_nxt    = afd_pkg::POS_SYNC_DONE;
              len_hi_nxt = 1'b0;
              crc_nxt    = afd_pkg::crc_byte(a_crc_r, afd_pkg::CHAR_F, poly_r);
            end else begin
              prev_a_nxt = (in_byte_r == afd_pkg::CHAR_A);
            end
          end
          afd_pkg::PH_HEADER: begin
            crc_nxt = afd_pkg::crc_byte(crc_r, in_byte_r, poly_r);
            // The two upper length bytes only need to be known as zero or not.
            if (cnt_r < afd_pkg::POS_LEN_END) begin
              len_nxt = {len_r[7:0], in_byte_r};
              if (cnt_r < afd_pkg::POS_LEN_HI_END && in_byte_r != 8'h00) begin
                len_hi_nxt = 1'b1;
              end
            end else if (cnt_r < afd_pkg::POS_SEQ_END) begin
              cur_seq_nxt = {cur_seq_r[7:0], in_byte_r};
            end else if (cnt_r == afd_pkg::POS_FLAGS) begin
              flags_nxt = in_byte_r;
            end else begin
              type_ok_nxt = (in_byte_r == afd_pkg::CHAR_T);
            end
            cnt_nxt = cnt_r + 16'd1;
            if (cnt_r == afd_pkg::POS_HDR_LAST) begin
              cnt_nxt = 16'd0;
              if (len_hi_r || len_r > max_len_r) begin
                finish     = 1'b1;
                fin_status = afd_pkg::ST_TOO_LONG;
              end else if (len_r == 16'd0) begin
                if (!flags_r[7]) begin
                  finish     = 1'b1;
                  fin_status = afd_pkg::ST_NO_CRC;
                end else begin
                  phase_nxt = afd_pkg::PH_CRC_HI;
                end
              end else begin
                phase_nxt = afd_pkg::PH_PAYLOAD;
              end
            end
          end
          afd_pkg::PH_PAYLOAD: begin
            crc_nxt    = afd_pkg::crc_byte(crc_r, in_byte_r, poly_r);
            o_byte_nxt = in_byte_r;
            o_bv_nxt   = 1'b1;
            emit       = 1'b1;
            cnt_nxt    = pay_count[15:0];
            if (pay_count >= {1'b0, len_r}) begin
              if (!flags_r[7]) begin
                finish     = 1'b1;
                fin_status = afd_pkg::ST_NO_CRC;
              end else begin
                phase_nxt = afd_pkg::PH_CRC_HI;
              end
            end
          end
          afd_pkg::PH_CRC_HI: begin
            rx_hi_nxt = in_byte_r;
            phase_nxt = afd_pkg::PH_CRC_LO;
          end
          afd_pkg::PH_CRC_LO: begin
            finish = 1'b1;
            if (!type_ok_r) begin
              fin_status = afd_pkg::ST_WRONG_TYPE;
            end else if ({rx_hi_r, in_byte_r} != ~crc_r) begin
              fin_status = afd_pkg::ST_CRC_BAD;
            end else begin
              fin_status = afd_pkg::ST_OK;
            end
          end
          default: begin
            phase_nxt  = afd_pkg::PH_HUNT;
            prev_a_nxt = 1'b0;
          end
        endcase

        if (finish) begin
          emit          = 1'b1;
          o_end_nxt     = 1'b1;
          o_status_nxt  = fin_status;
          o_seq_nxt     = cur_seq_r;
          o_gap_nxt     = seq_known_r && (cur_seq_r != last_seq_r + 16'd1);
          o_rev_nxt     = (flags_r[6:0] != afd_pkg::REV_EXPECTED);
          last_seq_nxt  = cur_seq_r;
          seq_known_nxt = 1'b1;
          phase_nxt     = afd_pkg::PH_HUNT;
          prev_a_nxt    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= afd_pkg::PH_HUNT;
      prev_a_r    <= 1'b0;
      seq_known_r <= 1'b0;
      crc_r       <= afd_pkg::CRC_INIT;
    end else begin
      phase_r     <= phase_nxt;
      prev_a_r    <= prev_a_nxt;
      seq_known_r <= seq_known_nxt;
      crc_r       <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    len_r      <= len_nxt;
    len_hi_r   <= len_hi_nxt;
    rx_hi_r    <= rx_hi_nxt;
    flags_r    <= flags_nxt;
    type_ok_r  <= type_ok_nxt;
    last_seq_r <= last_seq_nxt;
    cur_seq_r  <= cur_seq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_byte_r   <= o_byte_nxt;
      o_bv_r     <= o_bv_nxt;
      o_end_r    <= o_end_nxt;
      o_status_r <= o_status_nxt;
      o_seq_r    <= o_seq_nxt;
      o_gap_r    <= o_gap_nxt;
      o_rev_r    <= o_rev_nxt;
    end
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.payload_byte      = o_byte_r;
  assign out_if.byte_valid        = o_bv_r;
  assign out_if.packet_end        = o_end_r;
  assign out_if.end_status        = o_status_r;
  assign out_if.sequence_number   = o_seq_r;
  assign out_if.sequence_gap      = o_gap_r;
  assign out_if.revision_mismatch = o_rev_r;

endmodule
